@@ rtl/cfq_pkg.sv @@
// Shared types, constants and command codes of the circular queue FIFO core.
package cfq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 5;
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_STATUS = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_PUSH_FULL  = 2'd1,
        ST_POP_EMPTY  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic signed [WORD_W-1:0] push_value;
    } in_item_t;

    typedef struct packed {
        status_t                  status;
        logic signed [WORD_W-1:0] popped_value;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
        logic [CAP_W-1:0]         entry_count;
        logic                     is_empty;
        logic                     is_full;
    } out_item_t;

    // Control that every cell of the chain sees in the same cycle.
    typedef struct packed {
        logic             shift;
        logic             load;
        logic [CNT_W-1:0] fill;
    } cell_ctrl_t;

endpackage

@@ rtl/cfq_cell.sv @@
// One storage cell of the FIFO chain: holds one word and takes its neighbor's on a pop.
module cfq_cell (
    input  logic                              aclk,
    input  logic [cfq_pkg::IDX_W-1:0]         cell_index,
    input  cfq_pkg::cell_ctrl_t               ctrl,
    input  logic signed [cfq_pkg::WORD_W-1:0] push_word,
    input  logic signed [cfq_pkg::WORD_W-1:0] right_word,
    output logic signed [cfq_pkg::WORD_W-1:0] cell_word
);

    logic signed [cfq_pkg::WORD_W-1:0] word_reg;
    logic signed [cfq_pkg::WORD_W-1:0] word_next;
    logic                              is_tail;

    // This cell is the first free slot when its position equals the fill level.
    assign is_tail = ({1'b0, cell_index} == ctrl.fill);

    always_comb begin
        word_next = word_reg;
        if (ctrl.shift) begin
            word_next = right_word;
        end else if (ctrl.load && is_tail) begin
            word_next = push_word;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign cell_word = word_reg;

endmodule

@@ rtl/cfq_out_skid.sv @@
// Two-entry output buffer that decouples result production from the receiver.
module cfq_out_skid (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  cfq_pkg::out_item_t  in_item,
    output logic                m_valid,
    input  logic                m_ready,
    output cfq_pkg::out_item_t  m_data
);

    logic               main_valid_reg;
    logic               main_valid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    cfq_pkg::out_item_t main_reg;
    cfq_pkg::out_item_t main_next;
    cfq_pkg::out_item_t skid_reg;
    cfq_pkg::out_item_t skid_next;
    logic               main_free;

    assign main_free = !main_valid_reg || m_ready;
    assign in_ready  = !skid_valid_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_free) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_valid;
                if (in_valid) begin
                    main_next = in_item;
                end
            end
        end else if (in_valid && in_ready) begin
            skid_next       = in_item;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_valid = main_valid_reg;
    assign m_data  = main_reg;

endmodule

@@ rtl/circular_queue_fifo_core.sv @@
// Top level of the circular queue FIFO core: command decode, cell chain and result buffer.
//
// Usage: each transfer on the s_ channel carries one command (push, pop, clear or
// status only) with a push word. For every accepted command exactly one result
// transfer follows on the m_ channel, in order, with the status, the popped word,
// the front and back entries, the entry count and the empty and full flags as they
// stand after the command.
// The queue is held in a chain of cells ordered oldest first; a pop moves every
// cell one place toward the front together, a push loads the first free cell.
// The result of an input transfer is registered in the result buffer before m_ offers it.
// Throughput is one command per cycle while s_ready is high; the chain takes each in one update.
// A two-entry result buffer sits between the chain and m_, so a command is still
// accepted while one finished result waits; when the receiver stalls and both
// entries are full, s_ready drops until m_ready takes a result.
// The capacity in use is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while idle, which the block does not enforce. A value of zero is
// taken as one, a value above the depth as the depth, and every write empties the queue.
// Reset (aresetn low, synchronous) empties the queue, sets the capacity to the full
// depth and discards any result not yet transferred.
module circular_queue_fifo_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  cfq_pkg::in_item_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output cfq_pkg::out_item_t           m_data,
    input  logic                         cfg_wr_en,
    input  logic [cfq_pkg::CAP_W-1:0]    cfg_wr_data
);

    localparam logic [cfq_pkg::CNT_W-1:0] DepthCount = cfq_pkg::CNT_W'(cfq_pkg::DEPTH);
    localparam logic [cfq_pkg::CNT_W-1:0] OneCount   = cfq_pkg::CNT_W'(1);

    logic [cfq_pkg::CNT_W-1:0]          count_reg;
    logic [cfq_pkg::CNT_W-1:0]          count_next;
    logic [cfq_pkg::CNT_W-1:0]          cap_reg;
    logic [cfq_pkg::CNT_W-1:0]          cap_next;
    logic signed [cfq_pkg::WORD_W-1:0]  back_reg;
    logic signed [cfq_pkg::WORD_W-1:0]  back_next;
    logic signed [cfq_pkg::WORD_W-1:0]  cell_word [cfq_pkg::DEPTH];
    logic signed [cfq_pkg::WORD_W-1:0]  front_word;
    logic [cfq_pkg::CNT_W-1:0]          cap_wide;
    logic                               accept;
    logic                               is_full_now;
    logic                               is_empty_now;
    logic                               do_push;
    logic                               do_pop;
    logic                               do_clear;
    logic                               res_ready;
    cfq_pkg::cell_ctrl_t                ctrl;
    cfq_pkg::out_item_t                 result;

    assign s_ready = res_ready;
    assign accept  = s_valid && res_ready;

    assign is_full_now  = (count_reg >= cap_reg);
    assign is_empty_now = (count_reg == '0);
    assign do_push  = accept && (s_data.cmd == cfq_pkg::CMD_PUSH) && !is_full_now;
    assign do_pop   = accept && (s_data.cmd == cfq_pkg::CMD_POP) && !is_empty_now;
    assign do_clear = accept && (s_data.cmd == cfq_pkg::CMD_CLEAR);

    assign ctrl.shift = do_pop;
    assign ctrl.load  = do_push;
    assign ctrl.fill  = count_reg;

    // The chain: cell 0 holds the oldest entry, the last cell shifts in zero.
    for (genvar gi = 0; gi < cfq_pkg::DEPTH; gi++) begin : g_cell
        logic signed [cfq_pkg::WORD_W-1:0] right_word;
        if (gi == cfq_pkg::DEPTH - 1) begin : g_last
            assign right_word = '0;
        end else begin : g_mid
            assign right_word = cell_word[gi + 1];
        end
        cfq_cell u_cell (
            .aclk       (aclk),
            .cell_index (cfq_pkg::IDX_W'(gi)),
            .ctrl       (ctrl),
            .push_word  (s_data.push_value),
            .right_word (right_word),
            .cell_word  (cell_word[gi])
        );
    end

    // Capacity written through the configuration port, clamped into one to depth.
    assign cap_wide = cfq_pkg::CNT_W'(cfg_wr_data);

    always_comb begin
        cap_next = cap_reg;
        if (cfg_wr_en) begin
            if (cap_wide == '0) begin
                cap_next = OneCount;
            end else if (cap_wide > DepthCount) begin
                cap_next = DepthCount;
            end else begin
                cap_next = cap_wide;
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        back_next  = back_reg;
        if (cfg_wr_en || do_clear) begin
            count_next = '0;
        end else if (do_push) begin
            count_next = count_reg + OneCount;
            back_next  = s_data.push_value;
        end else if (do_pop) begin
            count_next = count_reg - OneCount;
        end
    end

    // The front after this command: a fixed chain cell, or the word pushed into empty.
    always_comb begin
        if (do_pop) begin
            front_word = (cfq_pkg::DEPTH > 1) ? cell_word[1 % cfq_pkg::DEPTH] : '0;
        end else if (do_push && is_empty_now) begin
            front_word = s_data.push_value;
        end else begin
            front_word = cell_word[0];
        end
    end

    always_comb begin
        result.status = cfq_pkg::ST_OK;
        if (s_data.cmd == cfq_pkg::CMD_PUSH && is_full_now) begin
            result.status = cfq_pkg::ST_PUSH_FULL;
        end else if (s_data.cmd == cfq_pkg::CMD_POP && is_empty_now) begin
            result.status = cfq_pkg::ST_POP_EMPTY;
        end
        result.popped_value = do_pop ? cell_word[0] : '0;
        result.front_value  = (count_next == '0) ? '0 : front_word;
        result.back_value   = (count_next == '0) ? '0 : back_next;
        result.entry_count  = cfq_pkg::CAP_W'(count_next);
        result.is_empty     = (count_next == '0);
        result.is_full      = (count_next == cap_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            cap_reg   <= DepthCount;
        end else begin
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    always_ff @(posedge aclk) begin
        back_reg <= back_next;
    end

    cfq_out_skid u_out_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (accept),
        .in_ready (res_ready),
        .in_item  (result),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ sim/circular_queue_fifo_core_test.sv @@
// Self-checking testbench of the circular queue FIFO core with a scoreboard class.
`timescale 1ns / 100ps

import cfq_pkg::*;

class fifo_scoreboard;
    // Results that accepted commands have promised, oldest first.
    out_item_t          awaited_results[$];
    logic [WORD_W-1:0]  model_ring [DEPTH];
    int unsigned        oldest_slot;
    int unsigned        free_slot;
    int unsigned        held_count;
    int unsigned        ring_size;
    int                 mismatches;

    function new();
        oldest_slot = 0;
        free_slot   = 0;
        held_count  = 0;
        ring_size   = DEPTH;
        mismatches  = 0;
    endfunction

    function int unsigned wrap_next(int unsigned slot);
        return (slot + 1 >= ring_size) ? 0 : slot + 1;
    endfunction

    // Any capacity write also empties the queue.
    function void write_capacity(logic [CAP_W-1:0] value);
        if (value == 0) begin
            ring_size = 1;
        end else if (value > DEPTH) begin
            ring_size = DEPTH;
        end else begin
            ring_size = 32'(value);
        end
        oldest_slot = 0;
        free_slot   = 0;
        held_count  = 0;
    endfunction

    // Apply one accepted command to the queue copy and note the result it must produce.
    function void record_command(in_item_t item);
        out_item_t   res;
        int unsigned newest;
        res = '0;
        res.status = ST_OK;
        case (item.cmd)
            CMD_PUSH: begin
                if (held_count >= ring_size) begin
                    res.status = ST_PUSH_FULL;
                end else begin
                    model_ring[free_slot] = item.push_value;
                    free_slot = wrap_next(free_slot);
                    held_count++;
                end
            end
            CMD_POP: begin
                if (held_count == 0) begin
                    res.status = ST_POP_EMPTY;
                end else begin
                    res.popped_value = model_ring[oldest_slot];
                    oldest_slot = wrap_next(oldest_slot);
                    held_count--;
                end
            end
            CMD_CLEAR: begin
                oldest_slot = 0;
                free_slot   = 0;
                held_count  = 0;
            end
            default: ;
        endcase
        if (held_count > 0) begin
            newest = (free_slot == 0) ? ring_size - 1 : free_slot - 1;
            res.front_value = model_ring[oldest_slot];
            res.back_value  = model_ring[newest];
        end
        res.entry_count = CAP_W'(held_count);
        res.is_empty    = (held_count == 0);
        res.is_full     = (held_count == ring_size);
        awaited_results.push_back(res);
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task check_result(out_item_t got);
        out_item_t want;
        if (awaited_results.size() == 0) begin
            report("result transfer with no command waiting for it");
        end else begin
            want = awaited_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.popped_value !== want.popped_value)
                report($sformatf("popped %0d, want %0d", got.popped_value, want.popped_value));
            if (got.front_value !== want.front_value)
                report($sformatf("front %0d, want %0d", got.front_value, want.front_value));
            if (got.back_value !== want.back_value)
                report($sformatf("back %0d, want %0d", got.back_value, want.back_value));
            if (got.entry_count !== want.entry_count)
                report($sformatf("count %0d, want %0d", got.entry_count, want.entry_count));
            if (got.is_empty !== want.is_empty)
                report($sformatf("empty flag %0b, want %0b", got.is_empty, want.is_empty));
            if (got.is_full !== want.is_full)
                report($sformatf("full flag %0b, want %0b", got.is_full, want.is_full));
        end
    endtask
endclass

module circular_queue_fifo_core_test;

    logic              aclk;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    in_item_t          s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    out_item_t         m_data;
    logic              cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]  cfg_wr_data = '0;

    fifo_scoreboard sb = new();

    // Remaining items of a stretch in which a side does not idle at all.
    int send_calm = 0;
    int recv_calm = 0;

    circular_queue_fifo_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The run should finish in a few tens of microseconds even with every wait at its longest;
    // this catches a hang in either handshake.
    initial begin
        #1000000;
        $display("circular_queue_fifo_core test failed");
        $finish;
    end

    // Every transfer is seen here at the edge where it happens. Signals are read before the
    // design's own updates of this edge land, so they hold the values the edge sampled.
    // The input is noted first, though a result can never come in the same cycle as its command.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.record_command(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // Wait length for one item: mostly drawn at random, with occasional runs of no wait at all.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // Push words lean on the signed extremes so that sign handling is exercised often.
    function automatic logic [WORD_W-1:0] draw_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Clear and status-only commands are kept rare; the rest splits between push and pop
    // by the given share, which steers the queue toward full or toward empty.
    function automatic cmd_t draw_cmd(int push_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) return CMD_CLEAR;
        if (pick < 10) return CMD_STATUS;
        if (pick < 10 + push_pct * 90 / 100) return CMD_PUSH;
        return CMD_POP;
    endfunction

    // Offers one command and returns at the edge where it is transferred. Valid is only
    // lowered when a gap is drawn, so back-to-back items keep it high without a glitch.
    task automatic send_cmd(input cmd_t c, input logic [WORD_W-1:0] word);
        int       gap;
        in_item_t item;
        gap = draw_wait(send_calm);
        item.cmd        = c;
        item.push_value = word;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Capacity writes happen only with the queue quiet: s_valid is low and every result
    // has come back before the write edge.
    task automatic set_capacity(input logic [CAP_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.awaited_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.write_capacity(value);
    endtask

    // The receiver stalls before each result for a drawn number of cycles, then holds ready
    // high until a result transfer takes place.
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int               phase_caps [8];
        int               push_bias  [3];
        logic [CAP_W-1:0] cap;
        phase_caps = '{1, 16, 31, 2, 0, 5, 17, 3};
        push_bias  = '{70, 30, 50};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset capacity (full depth): an empty queue is reported and a pop on it refused,
        // then the word extremes go through the queue, and clear drops what is left.
        send_cmd(CMD_STATUS, 32'h0000_0000);
        send_cmd(CMD_POP,    32'hFFFF_FFFF);
        send_cmd(CMD_PUSH,   32'h7FFF_FFFF);
        send_cmd(CMD_PUSH,   32'h8000_0000);
        send_cmd(CMD_PUSH,   32'h0000_0000);
        send_cmd(CMD_PUSH,   32'hFFFF_FFFF);
        send_cmd(CMD_STATUS, 32'h1234_5678);
        send_cmd(CMD_POP,    32'h0000_0000);
        send_cmd(CMD_POP,    32'h0000_0000);
        send_cmd(CMD_CLEAR,  32'hFFFF_FFFF);
        send_cmd(CMD_POP,    32'h0000_0000);

        // Two slots: fill, refuse a push when full, and wrap the tail so the newest entry is
        // read from the last slot of the ring.
        set_capacity(5'd2);
        send_cmd(CMD_PUSH, 32'h0000_0011);
        send_cmd(CMD_PUSH, 32'h8000_0022);
        send_cmd(CMD_PUSH, 32'h7FFF_FF33);
        send_cmd(CMD_POP,  32'h0000_0000);
        send_cmd(CMD_PUSH, 32'hFFFF_FF44);
        send_cmd(CMD_POP,  32'h0000_0000);
        send_cmd(CMD_POP,  32'h0000_0000);
        send_cmd(CMD_POP,  32'h0000_0000);

        // A written zero means a single slot.
        set_capacity(5'd0);
        send_cmd(CMD_PUSH,  32'hDEAD_BEEF);
        send_cmd(CMD_PUSH,  32'h0BAD_F00D);
        send_cmd(CMD_POP,   32'h0000_0000);
        send_cmd(CMD_CLEAR, 32'h0000_0000);

        // Random phases, each under its own capacity and push bias; the last two capacities
        // are drawn over the whole register range.
        for (int p = 0; p < 10; p++) begin
            cap = CAP_W'((p < 8) ? phase_caps[p] : $urandom_range(0, 31));
            set_capacity(cap);
            for (int n = 0; n < 85; n++) begin
                send_cmd(draw_cmd(push_bias[p % 3]), draw_word());
            end
        end

        s_valid <= 1'b0;
        while (sb.awaited_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
            $display("circular_queue_fifo_core test passed");
        end else begin
            $display("circular_queue_fifo_core test failed");
        end
        $finish;
    end

endmodule
